// ===== hw/rtl/ppvl_pkg.sv =====
// types and constants shared by the polar pose velocity law unit
package ppvl_pkg;

   localparam int PosW   = 32;
   localparam int HeadW  = 16;
   localparam int GainW  = 16;
   localparam int DiffW  = 33;
   localparam int XW     = 44;
   localparam int ZW     = 21;
   localparam int AngW   = 20;
   localparam int RhoW   = 36;
   localparam int XSplit = 22;

   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_GAIN_RHO   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_GAIN_ALPHA = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_GAIN_BETA  = 2'd2;

   localparam logic signed [ZW-1:0] PI_Q16       = 21'sd205887;
   localparam logic [15:0]          INV_GAIN_Q16 = 16'd39797;

   localparam logic signed [ZW-1:0] ATAN_TABLE [32] = '{
      21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047, 21'sd1024,
      21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32, 21'sd16, 21'sd8, 21'sd4, 21'sd2,
      21'sd1, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 21'sd0,
      21'sd0, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 21'sd0
   };

   typedef struct packed {
      logic signed [PosW-1:0]  robot_x;
      logic signed [PosW-1:0]  robot_y;
      logic signed [HeadW-1:0] robot_heading;
      logic signed [PosW-1:0]  goal_x;
      logic signed [PosW-1:0]  goal_y;
   } req_type;

   typedef struct packed {
      logic signed [PosW-1:0] linear_velocity;
      logic signed [PosW-1:0] angular_velocity;
   } rsp_type;

   typedef struct packed {
      logic                    zero;
      logic signed [HeadW-1:0] heading;
      logic signed [XW-1:0]    x;
      logic signed [XW-1:0]    y;
      logic signed [ZW-1:0]    z;
   } cordic_beat_type;

   typedef struct packed {
      logic signed [GainW-1:0] rho;
      logic signed [GainW-1:0] alpha;
      logic signed [GainW-1:0] beta;
   } gains_type;

endpackage

// ===== hw/rtl/ppvl_cordic_cell.sv =====
// one vectoring cordic iteration with its own pipeline register
module ppvl_cordic_cell
   import ppvl_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  cordic_beat_type in_beat,
   output logic            take,
   input  logic            down_take,
   output logic            out_valid,
   output cordic_beat_type out_beat
);

   localparam logic signed [ZW-1:0] ATAN_STEP = ATAN_TABLE[STEP];

   logic            valid_ff, valid_in;
   cordic_beat_type beat_ff, beat_in;
   logic signed [XW-1:0] xs, ys;

   assign take     = !valid_ff || down_take;
   assign valid_in = take ? in_valid : valid_ff;

   always_comb begin
      xs      = in_beat.x >>> STEP;
      ys      = in_beat.y >>> STEP;
      beat_in = in_beat;
      if (!in_beat.y[XW-1]) begin
         beat_in.x = in_beat.x + ys;
         beat_in.y = in_beat.y - xs;
         beat_in.z = in_beat.z + ATAN_STEP;
      end else begin
         beat_in.x = in_beat.x - ys;
         beat_in.y = in_beat.y + xs;
         beat_in.z = in_beat.z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   // x only grows once the vector sits in the right half plane
   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !beat_ff.x[XW-1])
      else $error("cordic x went negative");

endmodule

// ===== hw/rtl/ppvl_post.sv =====
// gain scaling, angle law and saturation after the cordic chain
module ppvl_post
   import ppvl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  cordic_beat_type in_beat,
   output logic            in_take,
   input  gains_type       gains,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   localparam int PhW  = XW - XSplit + 17;
   localparam int PlW  = XSplit + 16;
   localparam int SumW = PhW + XSplit + 1;
   localparam int LinW = RhoW + GainW;
   localparam int AngPW = AngW + GainW;

   function automatic logic signed [PosW-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi, lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[PosW-1:0];
      end
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic t1, t2, t3, t4;

   logic signed [PhW-1:0]   ph1_ff;
   logic [PlW-1:0]          pl1_ff;
   logic signed [AngW-1:0]  bearing1_ff;
   logic signed [HeadW-1:0] hd1_ff;
   logic                    zero1_ff;

   logic signed [RhoW-1:0] rho2_ff;
   logic signed [AngW-1:0] alpha2_ff, beta2_ff;

   logic signed [LinW-1:0]  plin3_ff;
   logic signed [AngPW-1:0] pa3_ff, pb3_ff;

   rsp_type out_ff;

   logic signed [ZW-1:0]    zr;
   logic signed [AngW-1:0]  bearing_in;
   logic signed [PhW-1:0]   ph_in;
   logic [PlW-1:0]          pl_in;
   logic signed [SumW-1:0]  rho_sum;
   logic signed [RhoW-1:0]  rho_in;
   logic signed [AngW-1:0]  hd_ext, alpha_in, beta_in;
   logic signed [LinW:0]    lin_sum;
   logic signed [AngPW:0]   ang_sum;
   rsp_type                 out_in;

   assign t4      = !v4_ff || !rsp_stall;
   assign t3      = !v3_ff || t4;
   assign t2      = !v2_ff || t3;
   assign t1      = !v1_ff || t2;
   assign in_take = t1;

   assign v1_in = t1 ? in_valid : v1_ff;
   assign v2_in = t2 ? v1_ff : v2_ff;
   assign v3_in = t3 ? v2_ff : v3_ff;
   assign v4_in = t4 ? v3_ff : v4_ff;

   always_comb begin
      zr         = (in_beat.z + ZW'(4)) >>> 3;
      bearing_in = in_beat.zero ? '0 : AngW'(zr);
      ph_in      = $signed(in_beat.x[XW-1:XSplit]) * $signed({1'b0, INV_GAIN_Q16});
      pl_in      = in_beat.x[XSplit-1:0] * INV_GAIN_Q16;

      rho_sum = ($signed(SumW'(ph1_ff)) <<< XSplit) + $signed(SumW'(pl1_ff))
                + SumW'(64'sd8388608);
      rho_in  = zero1_ff ? '0 : rho_sum[RhoW+23:24];
      hd_ext  = AngW'(hd1_ff);
      alpha_in = bearing1_ff - hd_ext;
      beta_in  = -hd_ext - alpha_in;

      lin_sum = (LinW+1)'(plin3_ff) + (LinW+1)'(128);
      ang_sum = (AngPW+1)'(pa3_ff) + (AngPW+1)'(pb3_ff) + (AngPW+1)'(16);
      out_in.linear_velocity  = sat32(64'(lin_sum >>> 8));
      out_in.angular_velocity = sat32(64'(ang_sum >>> 5));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (t1 && in_valid) begin
         ph1_ff      <= ph_in;
         pl1_ff      <= pl_in;
         bearing1_ff <= bearing_in;
         hd1_ff      <= in_beat.heading;
         zero1_ff    <= in_beat.zero;
      end
      if (t2 && v1_ff) begin
         rho2_ff   <= rho_in;
         alpha2_ff <= alpha_in;
         beta2_ff  <= beta_in;
      end
      if (t3 && v2_ff) begin
         plin3_ff <= rho2_ff * gains.rho;
         pa3_ff   <= alpha2_ff * gains.alpha;
         pb3_ff   <= beta2_ff * gains.beta;
      end
      if (t4 && v3_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = out_ff;

   // distance is never negative
   a_rho_nonneg: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> !rho2_ff[RhoW-1])
      else $error("negative distance");

endmodule

// ===== hw/rtl/polar_pose_velocity_law_unit.sv =====
// Polar pose velocity law unit: one pose and goal in, one linear and angular
// velocity command out. Fully pipelined: one item is accepted every cycle unless
// the output stall backs up the chain; each beat passes the front register, one
// cordic cell per iteration and four scaling stages before its result is offered.
// Every stage holds its own beat, so a stalled output only backs up the chain
// as far as the first empty stage. The user must write gains through the csr
// port while the unit is idle; the block itself does not enforce this. Writes to
// an unused index are dropped.
module polar_pose_velocity_law_unit
   import ppvl_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [GainW-1:0]   csr_data
);

   gains_type gains_ff, gains_in;

   logic            front_valid_ff, front_valid_in, front_take;
   cordic_beat_type front_beat_ff, front_beat_in;

   logic            chain_valid [CORDIC_STEPS+1];
   logic            chain_take  [CORDIC_STEPS+1];
   cordic_beat_type chain_beat  [CORDIC_STEPS+1];

   logic signed [DiffW-1:0] dx_pos, dx_neg, dy_pos, dy_neg, dx_sel, dy_sel;
   logic                    flip;

   assign csr_ready = 1'b1;

   always_comb begin
      gains_in = gains_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_RHO:   gains_in.rho   = csr_data;
            CSR_GAIN_ALPHA: gains_in.alpha = csr_data;
            CSR_GAIN_BETA:  gains_in.beta  = csr_data;
            default:        gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // front stage: differences and half-plane fold
   always_comb begin
      dx_pos = {req_data.goal_x[PosW-1], req_data.goal_x}
               - {req_data.robot_x[PosW-1], req_data.robot_x};
      dx_neg = {req_data.robot_x[PosW-1], req_data.robot_x}
               - {req_data.goal_x[PosW-1], req_data.goal_x};
      dy_pos = {req_data.goal_y[PosW-1], req_data.goal_y}
               - {req_data.robot_y[PosW-1], req_data.robot_y};
      dy_neg = {req_data.robot_y[PosW-1], req_data.robot_y}
               - {req_data.goal_y[PosW-1], req_data.goal_y};
      flip   = dx_pos[DiffW-1];
      dx_sel = flip ? dx_neg : dx_pos;
      dy_sel = flip ? dy_neg : dy_pos;

      front_beat_in.zero    = (req_data.goal_x == req_data.robot_x)
                              && (req_data.goal_y == req_data.robot_y);
      front_beat_in.heading = req_data.robot_heading;
      front_beat_in.x = {{(XW-DiffW-8){dx_sel[DiffW-1]}}, dx_sel, 8'd0};
      front_beat_in.y = {{(XW-DiffW-8){dy_sel[DiffW-1]}}, dy_sel, 8'd0};
      if (!flip) begin
         front_beat_in.z = '0;
      end else if (dy_pos[DiffW-1]) begin
         front_beat_in.z = -PI_Q16;
      end else begin
         front_beat_in.z = PI_Q16;
      end
   end

   assign front_take     = !front_valid_ff || chain_take[0];
   assign front_valid_in = front_take ? req_valid : front_valid_ff;
   assign req_stall      = !front_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (front_take && req_valid) begin
         front_beat_ff <= front_beat_in;
      end
   end

   assign chain_valid[0] = front_valid_ff;
   assign chain_beat[0]  = front_beat_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      ppvl_cordic_cell #(
         .STEP (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_beat   (chain_beat[k]),
         .take      (chain_take[k]),
         .down_take (chain_take[k+1]),
         .out_valid (chain_valid[k+1]),
         .out_beat  (chain_beat[k+1])
      );
   end

   ppvl_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CORDIC_STEPS]),
      .in_beat   (chain_beat[CORDIC_STEPS]),
      .in_take   (chain_take[CORDIC_STEPS]),
      .gains     (gains_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // an empty output register frees the whole chain
   a_free_chain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the polar pose velocity law unit
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppvl_pkg::*;

   localparam int CORDIC_STEPS = 16;
   localparam int LATENCY      = 1 + CORDIC_STEPS + 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_POSES = 1600;
   localparam int GAIN_PHASES  = 8;
   localparam int HEAD_LIMIT   = 25736;
   localparam logic [CsrIdxW-1:0]     CSR_UNUSED = 2'd3;
   localparam logic signed [PosW-1:0] POS_MAX    = 32'sh7fffffff;
   localparam logic signed [PosW-1:0] POS_MIN    = 32'sh80000000;
   localparam logic signed [GainW-1:0] GAIN_MAX  = 16'sh7fff;
   localparam logic signed [GainW-1:0] GAIN_MIN  = 16'sh8000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [GainW-1:0]   csr_data = '0;

   longint  gain_rho_now = 0;
   longint  gain_alpha_now = 0;
   longint  gain_beta_now = 0;
   rsp_type pending_cmds[$];
   int      errors = 0;
   int      poses_sent = 0;
   int      cmds_checked = 0;
   int      gain_settings = 0;
   int      send_idle_pct = 25;
   int      recv_idle_pct = 25;
   int      hold_req_count = 0;
   int      hold_served = 0;
   int      hold_left = 0;

   polar_pose_velocity_law_unit #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [PosW-1:0] clamp_word(input longint v);
      if (v > longint'(POS_MAX)) begin
         return POS_MAX;
      end
      if (v < longint'(POS_MIN)) begin
         return POS_MIN;
      end
      return v[PosW-1:0];
   endfunction

   // distance and bearing by vectoring cordic, then the polar control law
   function automatic rsp_type predict_cmd(input req_type p);
      longint  dx, dy, x, y, z, xs, ys, hd;
      longint  rho, bearing, alpha, beta;
      rsp_type r;
      dx = longint'($signed(p.goal_x)) - longint'($signed(p.robot_x));
      dy = longint'($signed(p.goal_y)) - longint'($signed(p.robot_y));
      hd = longint'($signed(p.robot_heading));
      rho = 0;
      bearing = 0;
      if (dx != 0 || dy != 0) begin
         x = dx * 256;
         y = dy * 256;
         z = 0;
         if (dx < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + longint'(ATAN_TABLE[i]);
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - longint'(ATAN_TABLE[i]);
            end
         end
         rho = (x * longint'(INV_GAIN_Q16) + (longint'(1) << 23)) >>> 24;
         bearing = (z + 4) >>> 3;
      end
      alpha = bearing - hd;
      beta = -hd - alpha;
      r.linear_velocity = clamp_word((rho * gain_rho_now + 128) >>> 8);
      r.angular_velocity =
         clamp_word((gain_alpha_now * alpha + gain_beta_now * beta + 16) >>> 5);
      return r;
   endfunction

   // gain shadow and expectations, both taken from accepted beats
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN_RHO:   gain_rho_now = longint'($signed(csr_data));
               CSR_GAIN_ALPHA: gain_alpha_now = longint'($signed(csr_data));
               CSR_GAIN_BETA:  gain_beta_now = longint'($signed(csr_data));
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pending_cmds.insert(pending_cmds.size(), predict_cmd(req_data));
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat lin %0d ang %0d", $time,
                     rsp_data.linear_velocity, rsp_data.angular_velocity);
         end else begin
            want = pending_cmds.pop_front();
            cmds_checked++;
            if (rsp_data.linear_velocity !== want.linear_velocity) begin
               errors++;
               $display("%0t: linear_velocity expected %0d got %0d", $time,
                        want.linear_velocity, rsp_data.linear_velocity);
            end
            if (rsp_data.angular_velocity !== want.angular_velocity) begin
               errors++;
               $display("%0t: angular_velocity expected %0d got %0d", $time,
                        want.angular_velocity, rsp_data.angular_velocity);
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold whenever one is requested
   always @(posedge clock) begin
      if (hold_served != hold_req_count) begin
         hold_served = hold_req_count;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic req_type pose(input logic signed [PosW-1:0] rx,
                                    input logic signed [PosW-1:0] ry,
                                    input logic signed [HeadW-1:0] hd,
                                    input logic signed [PosW-1:0] gx,
                                    input logic signed [PosW-1:0] gy);
      req_type p;
      p.robot_x = rx;
      p.robot_y = ry;
      p.robot_heading = hd;
      p.goal_x = gx;
      p.goal_y = gy;
      return p;
   endfunction

   function automatic logic signed [PosW-1:0] random_coord();
      case ($urandom_range(3))
         0: return int'($urandom_range(1 << 24)) - (1 << 23);
         1: return $urandom_range(1) ? POS_MAX : POS_MIN;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_pose();
      req_type     p;
      int unsigned sel;
      p.robot_x = random_coord();
      p.robot_y = random_coord();
      sel = $urandom_range(9);
      if (sel < 5) begin
         p.goal_x = p.robot_x + (int'($urandom_range(1 << 20)) - (1 << 19));
         p.goal_y = p.robot_y + (int'($urandom_range(1 << 20)) - (1 << 19));
      end else if (sel == 5) begin
         p.goal_x = p.robot_x;
         p.goal_y = p.robot_y;
      end else begin
         p.goal_x = random_coord();
         p.goal_y = random_coord();
      end
      if ($urandom_range(9) == 0) begin
         p.robot_heading = HeadW'($urandom);
      end else begin
         p.robot_heading = HeadW'(int'($urandom_range(2 * HEAD_LIMIT)) - HEAD_LIMIT);
      end
      return p;
   endfunction

   function automatic logic [GainW-1:0] random_gain();
      if ($urandom_range(1)) begin
         return GainW'(int'($urandom_range(1023)) - 512);
      end
      return GainW'($urandom);
   endfunction

   task automatic send_pose(input req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data <= random_pose();
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      poses_sent++;
   endtask

   task automatic drain_cmds();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_cmds.size() != 0);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [GainW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_gains(input logic [GainW-1:0] g_rho, input logic [GainW-1:0] g_alpha,
                            input logic [GainW-1:0] g_beta);
      write_reg(CSR_GAIN_RHO, g_rho);
      write_reg(CSR_GAIN_ALPHA, g_alpha);
      write_reg(CSR_GAIN_BETA, g_beta);
      csr_valid <= 1'b0;
      @(posedge clock);
      gain_settings++;
   endtask

   task automatic test_reset_gains();
      for (int i = 0; i < 4; i++) begin
         send_pose(random_pose());
      end
      drain_cmds();
   endtask

   task automatic test_directed_geometry();
      set_gains(16'sd256, 16'sd384, -16'sd128);
      send_pose(pose(5 << 16, -3 << 16, 1000, 5 << 16, -3 << 16));
      send_pose(pose(0, 0, 0, 0, 0));
      send_pose(pose(POS_MIN, 0, 0, POS_MAX, 0));
      send_pose(pose(POS_MAX, 0, 0, POS_MIN, 0));
      send_pose(pose(0, POS_MIN, 0, 0, POS_MAX));
      send_pose(pose(0, POS_MAX, 0, 0, POS_MIN));
      send_pose(pose(POS_MIN, POS_MIN, 0, POS_MAX, POS_MAX));
      send_pose(pose(0, 0, 0, -(1 << 16), 0));
      send_pose(pose(0, 0, 0, -(1 << 16), -(1 << 16)));
      send_pose(pose(0, 0, 0, -(1 << 16), 1 << 16));
      send_pose(pose(0, 0, 0, 0, 1 << 16));
      send_pose(pose(0, 0, 0, 0, -(1 << 16)));
      send_pose(pose(0, 0, HEAD_LIMIT, 1 << 16, 1 << 16));
      send_pose(pose(0, 0, -HEAD_LIMIT, 1 << 16, 1 << 16));
      send_pose(pose(0, 0, 16'sh7fff, -(2 << 16), 1 << 16));
      send_pose(pose(0, 0, 16'sh8000, -(2 << 16), -(1 << 16)));
      send_pose(pose(0, 0, 0, 1, 0));
      send_pose(pose(0, 0, 0, -1, 1));
      drain_cmds();
   endtask

   task automatic test_gain_extremes();
      // a write to the spare index must leave all gains alone
      write_reg(CSR_UNUSED, 16'hffff);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_pose(pose(0, 0, 500, 3 << 16, 4 << 16));
      drain_cmds();
      set_gains(GAIN_MAX, GAIN_MAX, GAIN_MIN);
      send_pose(pose(POS_MIN, POS_MIN, 16'sh8000, POS_MAX, POS_MAX));
      send_pose(pose(POS_MAX, 0, HEAD_LIMIT, POS_MIN, 1 << 16));
      drain_cmds();
      set_gains(GAIN_MIN, GAIN_MIN, GAIN_MAX);
      send_pose(pose(POS_MIN, POS_MIN, 16'sh7fff, POS_MAX, POS_MAX));
      send_pose(pose(POS_MAX, 0, -HEAD_LIMIT, POS_MIN, -(1 << 16)));
      drain_cmds();
   endtask

   task automatic test_random_poses();
      for (int ph = 0; ph < GAIN_PHASES; ph++) begin
         case (ph)
            0: set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
            1: set_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN);
            2: set_gains(16'sd0, 16'sd0, 16'sd0);
            default: set_gains(random_gain(), random_gain(), random_gain());
         endcase
         for (int i = 0; i < RANDOM_POSES / GAIN_PHASES; i++) begin
            send_pose(random_pose());
         end
         drain_cmds();
      end
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      hold_req_count <= hold_req_count + 1;
      for (int i = 0; i < 80; i++) begin
         send_pose(random_pose());
      end
      drain_cmds();
      send_idle_pct = 25;
   endtask

   task automatic test_steady_stream();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 150; i++) begin
         send_pose(random_pose());
      end
      drain_cmds();
      send_idle_pct = 25;
      recv_idle_pct = 25;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_gains();
      test_directed_geometry();
      test_gain_extremes();
      test_random_poses();
      test_output_backpressure();
      test_steady_stream();
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d pose beats under %0d gain settings, %0d commands checked",
               poses_sent, gain_settings, cmds_checked);
      $display("included extreme offsets, goal on robot, headings beyond pi, long output hold");
      if (errors == 0 && pending_cmds.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ppvl_pkg.sv
hw/rtl/ppvl_cordic_cell.sv
hw/rtl/ppvl_post.sv
hw/rtl/polar_pose_velocity_law_unit.sv
sim/tb.sv
